// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the ready queue RTL.
// Each macro expects the signals clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never be true.
`define PRQ_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
// Package for the priority ready queue: sizes, codes, state type and the link port struct.
// No dependencies; used by prq_link_store and priority_ready_queue.
package prq_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int LINK_BITS  = $clog2(SLOT_COUNT + 1);
  localparam int PRIO_BITS  = 8;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [LINK_BITS-1:0] link_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  localparam link_t NO_SLOT = LINK_BITS'(SLOT_COUNT);

  typedef enum logic {
    CMD_ACTIVATE  = 1'b0,
    CMD_TERMINATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_FREE = 2'd1,
    ERR_EMPTY   = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_WALK,
    S_LINK,
    S_LINK_PREV,
    S_TERM,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    link_t wr_data;
  } link_req_t;

  function automatic logic is_slot(link_t v);
    return v < LINK_BITS'(SLOT_COUNT);
  endfunction

  function automatic link_t clamp_link(link_t v);
    return is_slot(v) ? v : NO_SLOT;
  endfunction

  // After reset every slot links to the following one; the last one links to none.
  function automatic link_t link_reset(slot_t s);
    return LINK_BITS'(s) + LINK_BITS'(1);
  endfunction

endpackage

// ===== hdl/prq_link_store.sv =====
// Link memory of the ready queue: one next link per slot, one read and one write port.
// Per-entry valid bits give the reset free chain without a clearing pass. Uses prq_pkg.
module prq_link_store
  import prq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  link_req_t req,
  output link_t     rd_data
);

  link_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= written[req.rd_addr] ? mem[req.rd_addr] : link_reset(req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== hdl/priority_ready_queue.sv =====
// Priority ready queue: a sorted linked list of task slots with a free list.
// Each accepted beat on the input channel (command, task_priority, insert_at_head)
// gives one beat on the output channel (slot_used, head_slot, head_changed, error_code).
// An activate takes the first free slot and walks the ready list from its head, one
// link and priority read per cycle, until it finds the insertion point; it then links
// the new entry and, when the new entry is not the head, the entry before it. A
// terminate moves the head slot onto the free list, and an item rejected with an error
// goes straight to its result. The single read port of the link memory sets the walk
// rate. One item is in work at a time; the next is accepted in the cycle after the
// result has been loaded into the output register.
// While the receiver stalls, one result waits in the output register and the next item
// is worked and then held in its final state, which keeps the input stalled until the
// output register frees.
// Reset leaves the ready list empty and chains all slots on the free list in order; it
// needs no clearing pass. Depends on prq_pkg, prq_link_store and assert_macros.svh.
`include "assert_macros.svh"

module priority_ready_queue
  import prq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] task_priority,
  input  logic       insert_at_head,
  output logic       out_valid,
  input  logic       out_ready,
  output slot_t      slot_used,
  output link_t      head_slot,
  output logic       head_changed,
  output logic [1:0] error_code
);

  state_t    state, state_next;
  link_t     ready_head, free_head, old_head, cur, prev;
  slot_t     slot;
  prio_t     item_prio;
  logic      ahead;
  err_t      err;

  link_req_t link_req;
  link_t     link_rd;
  link_t     nxt;

  prio_t     prio_mem [SLOT_COUNT];
  prio_t     prio_rd;
  logic      prio_wr_en, prio_rd_en;
  slot_t     prio_wr_addr, prio_rd_addr;

  logic      accept, out_free, walk_go;

  prq_link_store u_links (
    .clk     (clk),
    .rst     (rst),
    .req     (link_req),
    .rd_data (link_rd)
  );

  function automatic prio_t item_prio_in();
    return prio_t'(task_priority);
  endfunction

  always_ff @(posedge clk) begin
    if (prio_wr_en) begin
      prio_mem[prio_wr_addr] <= item_prio_in();
    end
    if (prio_rd_en) begin
      prio_rd <= prio_mem[prio_rd_addr];
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign nxt      = clamp_link(link_rd);
  assign walk_go  = (prio_rd > item_prio) || (!ahead && (prio_rd == item_prio));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(command) == CMD_ACTIVATE) begin
            state_next = is_slot(free_head) ? S_FREE : S_RESULT;
          end else begin
            state_next = is_slot(ready_head) ? S_TERM : S_RESULT;
          end
        end
      end
      S_FREE:      state_next = is_slot(cur) ? S_WALK : S_LINK;
      S_WALK:      state_next = (walk_go && is_slot(nxt)) ? S_WALK : S_LINK;
      S_LINK:      state_next = is_slot(prev) ? S_LINK_PREV : S_RESULT;
      S_LINK_PREV: state_next = S_RESULT;
      S_TERM:      state_next = S_RESULT;
      S_RESULT:    state_next = out_free ? S_IDLE : S_RESULT;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    link_req     = '0;
    prio_wr_en   = 1'b0;
    prio_wr_addr = free_head[SLOT_BITS-1:0];
    prio_rd_en   = 1'b0;
    prio_rd_addr = cur[SLOT_BITS-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(command) == CMD_ACTIVATE) begin
            if (is_slot(free_head)) begin
              link_req.rd_en   = 1'b1;
              link_req.rd_addr = free_head[SLOT_BITS-1:0];
              prio_wr_en       = 1'b1;
            end
          end else if (is_slot(ready_head)) begin
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = ready_head[SLOT_BITS-1:0];
          end
        end
      end
      S_FREE: begin
        if (is_slot(cur)) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = cur[SLOT_BITS-1:0];
          prio_rd_en       = 1'b1;
        end
      end
      S_WALK: begin
        if (walk_go && is_slot(nxt)) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = nxt[SLOT_BITS-1:0];
          prio_rd_en       = 1'b1;
          prio_rd_addr     = nxt[SLOT_BITS-1:0];
        end
      end
      S_LINK: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = slot;
        link_req.wr_data = cur;
      end
      S_LINK_PREV: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = prev[SLOT_BITS-1:0];
        link_req.wr_data = LINK_BITS'(slot);
      end
      S_TERM: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = old_head[SLOT_BITS-1:0];
        link_req.wr_data = clamp_link(free_head);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ready_head <= NO_SLOT;
      free_head  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_FREE: free_head <= nxt;
        S_LINK: begin
          if (!is_slot(prev)) begin
            ready_head <= LINK_BITS'(slot);
          end
        end
        S_TERM: begin
          ready_head <= nxt;
          free_head  <= old_head;
        end
        default: begin
        end
      endcase
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          old_head  <= clamp_link(ready_head);
          cur       <= clamp_link(ready_head);
          prev      <= NO_SLOT;
          item_prio <= item_prio_in();
          ahead     <= insert_at_head;
          if (cmd_t'(command) == CMD_ACTIVATE) begin
            slot <= is_slot(free_head) ? free_head[SLOT_BITS-1:0] : '0;
            err  <= is_slot(free_head) ? ERR_NONE : ERR_NO_FREE;
          end else begin
            slot <= is_slot(ready_head) ? ready_head[SLOT_BITS-1:0] : '0;
            err  <= is_slot(ready_head) ? ERR_NONE : ERR_EMPTY;
          end
        end
      end
      S_WALK: begin
        if (walk_go) begin
          prev <= cur;
          cur  <= nxt;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          slot_used    <= slot;
          head_slot    <= ready_head;
          head_changed <= (ready_head != old_head);
          error_code   <= err;
        end
      end
      default: begin
      end
    endcase
  end

  `PRQ_ASSERT_IMP(a_walk_skips_new_slot, state == S_WALK, cur != LINK_BITS'(slot),
    "list walk reached the slot being inserted")
  `PRQ_ASSERT_NEVER(a_lists_disjoint, is_slot(free_head) && (free_head == ready_head),
    "free list and ready list share their first slot")
  `PRQ_ASSERT_NEVER(a_link_port_conflict, link_req.rd_en && link_req.wr_en,
    "link memory read and written in the same cycle")
  `PRQ_ASSERT_IMP(a_empty_error_result, out_valid && (error_code == ERR_EMPTY),
    (head_slot == NO_SLOT) && !head_changed,
    "empty-queue error reported with a running task")

endmodule
